[rtl/core/ipt_pkg.sv]
package ipt_pkg;

	localparam int Frames     = 2048;
	localparam int MaxProcs   = 16;
	localparam int OffsetBits = 12;
	localparam int PidW       = 16;
	localparam int VaW        = 32;
	localparam int PageW      = VaW - OffsetBits;
	localparam int PaW        = 23;
	localparam int FrameW     = $clog2(Frames);
	localparam int SlotW      = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
	localparam int FcntW      = $clog2(Frames + 1);
	localparam int ScntW      = $clog2(MaxProcs + 1);

	typedef enum logic [2:0] {
		ST_HIT        = 3'd0,
		ST_INSERTED   = 3'd1,
		ST_REGISTERED = 3'd2,
		ST_REFUSED    = 3'd3,
		ST_TABLE_FULL = 3'd4
	} status_t;

	typedef struct packed {
		logic [PidW-1:0] process_id;
		logic [VaW-1:0]  virtual_address;
		logic            is_write;
	} req_t;

	typedef struct packed {
		logic [PaW-1:0] physical_address;
		logic [2:0]     status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PSCAN,
		S_DECIDE,
		S_FSCAN,
		S_RESP
	} state_t;

	// one frame entry, combined valid/owner/page/flags
	typedef struct packed {
		logic            valid;
		logic [PidW-1:0] owner;
		logic [PageW-1:0] page;
		logic            referenced;
		logic            dirty;
	} frame_t;

endpackage

[rtl/core/ipt_slot_cell.sv]
// one process slot of the rotating ring; passes its id to the next cell each shift
module ipt_slot_cell import ipt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  logic            load,
	input  logic [PidW-1:0] load_pid,
	input  logic [PidW-1:0] prev_pid,
	output logic [PidW-1:0] pid
);
	logic [PidW-1:0] pid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_q <= '0;
		end else if (load) begin
			pid_q <= load_pid;
		end else if (shift) begin
			pid_q <= prev_pid;
		end
	end

	assign pid = pid_q;
endmodule

[rtl/core/ipt_frame_mem.sv]
// frame table store: one write port, one registered read port
module ipt_frame_mem import ipt_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [FrameW-1:0] waddr,
	input  frame_t            wdata,
	input  logic [FrameW-1:0] raddr,
	output frame_t            rdata
);
	frame_t mem [Frames];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/inverted_page_table_translate.sv]
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_ready | req   (req_t: process_id, virtual_address, is_write)
// rsp     | out | rsp_valid/rsp_ready | rsp   (rsp_t: physical_address, status)
//
// Steps: a word rotates the slot ring once through every slot, takes a decision
//   state, then for a known id scans the frames in use (fill) in turn through the
//   registered read port, and is loaded into the response register.
// Reset: all slots clear at once; frames are tracked by a fill count, since
//   frames fill strictly in index order and are never freed, so no clear pass.
// Stalls: a finished result waits in S_RESP until the response register is free;
//   req_ready is high only in S_IDLE, so one word is in flight at a time.
module inverted_page_table_translate import ipt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);
	state_t state_q, state_d;

	req_t              req_q;
	logic [ScntW-1:0]  scnt_q;      // ring rotation count
	logic              known_q;
	logic              free_seen_q;
	logic [SlotW-1:0]  free_idx_q;  // lowest free slot seen in the rotation
	logic [FcntW-1:0]  fill_q;      // frames in use, always the low indexes
	logic [FcntW-1:0]  fidx_q;      // frame read address; rdata holds fidx_q - 1
	rsp_t              res_q;       // finished result, waiting for the output reg
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic            ring_shift;
	logic            slot_load;
	logic            mem_we;
	logic            rsp_load;

	logic [PageW-1:0]      req_page;
	logic [OffsetBits-1:0] req_off;
	assign req_page = req_q.virtual_address[VaW-1:OffsetBits];
	assign req_off  = req_q.virtual_address[OffsetBits-1:0];

	// slot ring: cell 0 is the head compared on each shift; a full rotation puts
	// every id back in its own cell
	logic [PidW-1:0] slot_pid [MaxProcs];
	logic [PidW-1:0] head_pid;

	assign head_pid = slot_pid[0];

	for (genvar g = 0; g < MaxProcs; g++) begin : g_slot
		logic [PidW-1:0] prev;
		if (g == MaxProcs - 1) begin : g_wrap
			assign prev = slot_pid[0];
		end else begin : g_mid
			assign prev = slot_pid[g+1];
		end
		ipt_slot_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (ring_shift),
			.load     (slot_load && (free_idx_q == SlotW'(g))),
			.load_pid (req_q.process_id),
			.prev_pid (prev),
			.pid      (slot_pid[g])
		);
	end

	// frame store
	frame_t            mem_wdata;
	frame_t            mem_rdata;
	logic [FrameW-1:0] mem_raddr;

	assign mem_raddr = fidx_q[FrameW-1:0];
	assign mem_wdata = '{valid: 1'b1, owner: req_q.process_id,
		page: req_page, referenced: 1'b1, dirty: req_q.is_write};

	ipt_frame_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (fill_q[FrameW-1:0]),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// frame scan compare on the entry read last cycle
	logic             scan_hit;
	logic             scan_last;
	logic             table_full;
	logic [FcntW-1:0] hit_idx;
	logic [PaW-1:0]   hit_pa;
	logic [PaW-1:0]   ins_pa;

	assign scan_hit   = mem_rdata.valid && mem_rdata.owner == req_q.process_id &&
		mem_rdata.page == req_page;
	assign scan_last  = (fidx_q == fill_q);
	assign table_full = (fill_q == FcntW'(Frames));
	assign hit_idx    = fidx_q - FcntW'(1);
	assign hit_pa     = PaW'({hit_idx, req_off});
	assign ins_pa     = PaW'({fill_q, req_off});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ring_shift = 1'b0;
		slot_load  = 1'b0;
		mem_we     = 1'b0;
		rsp_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_PSCAN;
				end
			end
			S_PSCAN: begin
				ring_shift = 1'b1;
				if (scnt_q == ScntW'(MaxProcs - 1)) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!known_q) begin
					// id zero is never registered
					slot_load = (req_q.process_id != '0) && free_seen_q;
					state_d   = S_RESP;
				end else if (fill_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_RESP;
				end else begin
					state_d = S_FSCAN;
				end
			end
			S_FSCAN: begin
				if (scan_hit) begin
					state_d = S_RESP;
				end else if (scan_last) begin
					mem_we  = !table_full;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q      <= '0;
			known_q     <= 1'b0;
			free_seen_q <= 1'b0;
			free_idx_q  <= '0;
			fill_q      <= '0;
			fidx_q      <= '0;
			res_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					scnt_q      <= '0;
					known_q     <= 1'b0;
					free_seen_q <= 1'b0;
					free_idx_q  <= '0;
					fidx_q      <= '0;
				end
				S_PSCAN: begin
					scnt_q <= scnt_q + ScntW'(1);
					if (head_pid == req_q.process_id && req_q.process_id != '0) begin
						known_q <= 1'b1;
					end
					if (head_pid == '0 && !free_seen_q) begin
						free_seen_q <= 1'b1;
						free_idx_q  <= SlotW'(scnt_q);
					end
				end
				S_DECIDE: begin
					// entry 0 is read at this edge, so the next address is 1
					fidx_q <= FcntW'(1);
					if (!known_q) begin
						res_q.physical_address <= '0;
						res_q.status <= slot_load ? ST_REGISTERED : ST_REFUSED;
					end else if (fill_q == '0) begin
						res_q.physical_address <= ins_pa;
						res_q.status           <= ST_INSERTED;
					end
				end
				S_FSCAN: begin
					fidx_q <= fidx_q + FcntW'(1);
					if (scan_hit) begin
						res_q.physical_address <= hit_pa;
						res_q.status           <= ST_HIT;
					end else if (scan_last) begin
						if (table_full) begin
							res_q.physical_address <= '0;
							res_q.status           <= ST_TABLE_FULL;
						end else begin
							res_q.physical_address <= ins_pa;
							res_q.status           <= ST_INSERTED;
						end
					end
				end
				default: ;
			endcase
			if (mem_we) begin
				fill_q <= fill_q + FcntW'(1);
			end
		end
	end

	// request capture and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_IDLE && req_valid) begin
				req_q <= req;
			end
			if (rsp_load) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;
	assign req_ready = (state_q == S_IDLE);
endmodule

[sim/inverted_page_table_translate_tb.sv]
module inverted_page_table_translate_tb import ipt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 3000000;
	localparam int RandomWords = 270;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	inverted_page_table_translate DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the translation state. Frames fill in index order and are
	// never freed, so a fill count plus owner/page arrays is all we need.
	logic [PidW-1:0]  shadow_slot [MaxProcs];
	logic [PidW-1:0]  shadow_owner [Frames];
	logic [PageW-1:0] shadow_page [Frames];
	int               shadow_fill;

	rsp_t pending_rsp [$];
	int   fail_count = 0;
	longint unsigned cycle_count = 0;
	logic long_hold = 1'b0;

	// Work out the response for one word and advance the shadow state.
	function automatic rsp_t translate_word(req_t w);
		rsp_t r;
		logic [PageW-1:0] pg;
		logic [OffsetBits-1:0] off;
		bit known;
		int free_slot;
		r = '0;
		pg = w.virtual_address[VaW-1:OffsetBits];
		off = w.virtual_address[OffsetBits-1:0];
		known = 0;
		free_slot = -1;
		for (int i = 0; i < MaxProcs; i++) begin
			if (w.process_id != '0 && shadow_slot[i] == w.process_id)
				known = 1;
			if (free_slot < 0 && shadow_slot[i] == '0)
				free_slot = i;
		end
		if (!known) begin
			// id zero is never registered
			if (w.process_id != '0 && free_slot >= 0) begin
				shadow_slot[free_slot] = w.process_id;
				r.status = ST_REGISTERED;
			end else begin
				r.status = ST_REFUSED;
			end
			return r;
		end
		for (int i = 0; i < shadow_fill; i++) begin
			if (shadow_owner[i] == w.process_id && shadow_page[i] == pg) begin
				r.physical_address = PaW'((i << OffsetBits) | off);
				r.status = ST_HIT;
				return r;
			end
		end
		if (shadow_fill < Frames) begin
			shadow_owner[shadow_fill] = w.process_id;
			shadow_page[shadow_fill] = pg;
			r.physical_address = PaW'((shadow_fill << OffsetBits) | off);
			r.status = ST_INSERTED;
			shadow_fill++;
		end else begin
			r.status = ST_TABLE_FULL;
		end
		return r;
	endfunction

	// Send one word: hold valid until accepted, then record its expectation.
	task automatic send_word(req_t w, bit typed, rsp_t typed_rsp);
		rsp_t predicted;
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (!req_ready);
		predicted = translate_word(w);
		if (typed && predicted != typed_rsp) begin
			$error("directed row disagrees with predictor: %h vs %h", typed_rsp, predicted);
			fail_count++;
		end
		pending_rsp.push_back(predicted);
	endtask

	task automatic idle_gap(int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Directed rows; typed result only where it is obvious.
	typedef struct {
		req_t w;
		bit   typed;
		rsp_t r;
	} row_t;

	function automatic req_t mk(logic [15:0] p, logic [31:0] va, logic wr);
		req_t w;
		w.process_id = p;
		w.virtual_address = va;
		w.is_write = wr;
		return w;
	endfunction

	function automatic rsp_t rs(logic [PaW-1:0] a, status_t s);
		rsp_t r;
		r.physical_address = a;
		r.status = s;
		return r;
	endfunction

	// Pick a process id: mostly a registered one so that words translate.
	function automatic logic [15:0] pick_pid();
		int k;
		k = $urandom_range(0, 99);
		if (k < 80)
			return shadow_slot[$urandom_range(0, MaxProcs - 1)];
		if (k < 85)
			return '0;
		return 16'($urandom_range(0, 65535));
	endfunction

	initial begin
		row_t rows [$];
		req_t w;
		for (int i = 0; i < MaxProcs; i++)
			shadow_slot[i] = '0;
		shadow_fill = 0;

		// unknown id zero, extremes of address
		rows.push_back('{mk(16'h0000, 32'hFFFF_FFFF, 1'b1), 1, rs('0, ST_REFUSED)});
		// first sight of an id registers it
		rows.push_back('{mk(16'h0001, 32'h0000_0000, 1'b0), 1, rs('0, ST_REGISTERED)});
		// first frame, zero offset and max offset
		rows.push_back('{mk(16'h0001, 32'h0000_0000, 1'b0), 1, rs('0, ST_INSERTED)});
		rows.push_back('{mk(16'h0001, 32'h0000_0FFF, 1'b1), 1, rs(23'h000FFF, ST_HIT)});
		rows.push_back('{mk(16'h0001, 32'hFFFF_FFFF, 1'b1), 1, rs(23'h001FFF, ST_INSERTED)});
		rows.push_back('{mk(16'hFFFF, 32'hFFFF_F000, 1'b0), 1, rs('0, ST_REGISTERED)});
		// same page, other owner: no hit across ids
		rows.push_back('{mk(16'hFFFF, 32'hFFFF_F123, 1'b0), 1, rs(23'h002123, ST_INSERTED)});
		rows.push_back('{mk(16'h0001, 32'hFFFF_F456, 1'b0), 1, rs(23'h001456, ST_HIT)});
		rows.push_back('{mk(16'h0000, 32'h0000_0000, 1'b0), 1, rs('0, ST_REFUSED)});
		rows.push_back('{mk(16'hAAAA, 32'h5555_5555, 1'b1), 0, '0});
		rows.push_back('{mk(16'h5555, 32'hAAAA_AAAA, 1'b0), 0, '0});
		// fill every process slot, then one more is refused
		for (int i = 0; i < MaxProcs - 4; i++)
			rows.push_back('{mk(16'(16'h0100 + i), 32'h0, 1'b0), 1, rs('0, ST_REGISTERED)});
		rows.push_back('{mk(16'h7777, 32'h1234_5678, 1'b1), 1, rs('0, ST_REFUSED)});
		rows.push_back('{mk(16'hAAAA, 32'h5555_5555, 1'b1), 0, '0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_word(rows[i].w, rows[i].typed, rows[i].r);

		// Random part, bursts and gaps. Ids come from a pool whose slots are
		// already full, so most words translate and the frame table grows.
		for (int n = 0; n < RandomWords; ) begin
			int burst;
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && n < RandomWords; b++, n++) begin
				w.process_id = pick_pid();
				if (($urandom & 1) && shadow_fill > 0) begin
					int f;
					f = $urandom_range(0, shadow_fill - 1);
					// revisit a mapped page, mostly under its owner
					w.process_id = ($urandom_range(0, 3) != 0) ? shadow_owner[f] : w.process_id;
					w.virtual_address = {shadow_page[f], 12'($urandom)};
				end else begin
					w.virtual_address = $urandom;
				end
				w.is_write = 1'($urandom);
				send_word(w, 0, '0);
			end
			if ($urandom_range(0, 2) != 0)
				idle_gap($urandom_range(1, 8));
		end
		req_valid <= 1'b0;

		wait (pending_rsp.size() == 0);
		repeat (MaxProcs + Frames + 20) @(posedge clk);
		if (fail_count == 0)
			$display("inverted_page_table_translate_tb OK");
		else
			$display("inverted_page_table_translate_tb NOT OK");
		$finish;
	end

	// Receiver: stalls on its own pattern, with stretches of full readiness.
	initial begin
		int phase;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase++;
			if (long_hold)
				rsp_ready <= 1'b0;
			else if ((phase / 64) % 3 == 2)
				rsp_ready <= 1'b1;
			else
				rsp_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// One long hold-off early on so the block backs up against its input.
	initial begin
		@(posedge arst_n);
		repeat (30) @(posedge clk);
		long_hold <= 1'b1;
		repeat (600) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response word with nothing expected: %h", rsp);
				fail_count++;
			end else begin
				rsp_t e;
				e = pending_rsp.pop_front();
				if (rsp.physical_address !== e.physical_address) begin
					$error("physical_address expected %h actual %h",
						e.physical_address, rsp.physical_address);
					fail_count++;
				end
				if (rsp.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, rsp.status);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("inverted_page_table_translate_tb NOT OK");
			$finish;
		end
	end

endmodule

[filelist.f]
rtl/core/ipt_pkg.sv
rtl/core/ipt_slot_cell.sv
rtl/core/ipt_frame_mem.sv
rtl/core/inverted_page_table_translate.sv
sim/inverted_page_table_translate_tb.sv
